/* hw/rtl/utf8_codepoint_range_filter_assert.svh */
// assertion macros for the utf8 code point range filter
`ifndef UTF8_CODEPOINT_RANGE_FILTER_ASSERT_SVH
`define UTF8_CODEPOINT_RANGE_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define UCF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define UCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UCF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define UCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/ucf_pkg.sv */
// shared types, constants and the code point range check of the utf8 filter
`default_nettype none

package ucf_pkg;

    // most results that one input byte can produce
    localparam int MAX_RESULTS = 4;

    localparam int CP_W = 21;

    // register index of the configuration port
    localparam logic REG_MAX_OUTPUT_BYTES = 1'b0;

    localparam logic [15:0] MAX_OUTPUT_BYTES_RESET = 16'd4096;

    // one result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       end_of_string;
    } ucf_result_t;

    // all results of one input byte, in order
    typedef struct packed {
        logic [2:0]                        count;
        ucf_result_t [MAX_RESULTS-1:0]     entry;
    } ucf_batch_t;

    // code points that are passed on
    function automatic logic cp_allowed(input logic [CP_W-1:0] cp);
        logic ok;
        ok = 1'b0;
        if (cp == 21'h09 || cp == 21'h0A || cp == 21'h0D) ok = 1'b1;
        if (cp >= 21'h20 && cp <= 21'h7E) ok = 1'b1;
        if (cp >= 21'h0400 && cp <= 21'h052F) ok = 1'b1;
        if (cp >= 21'h2600 && cp <= 21'h27BF) ok = 1'b1;
        if (cp >= 21'h1F300 && cp <= 21'h1F64F) ok = 1'b1;
        if (cp >= 21'h1F680 && cp <= 21'h1F6FF) ok = 1'b1;
        return ok;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ucf_result_fifo.sv */
// result queue: takes up to four results per cycle, gives one per cycle while the reader is ready
`default_nettype none

module ucf_result_fifo #(
    parameter int DEPTH = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire ucf_pkg::ucf_batch_t        wr_batch,
    output ucf_pkg::ucf_result_t            rd_data,
    output logic                            rd_valid,
    input  wire logic                       rd_ready,
    output logic                            room,
    output logic [$clog2(DEPTH+1)-1:0]      level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    ucf_pkg::ucf_result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [2:0]       push_n;
    logic             pop;

    assign push_n   = wr_en ? wr_batch.count : 3'd0;
    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (level_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign room     = (level_reg <= LVL_W'(DEPTH - ucf_pkg::MAX_RESULTS));
    assign level    = level_reg;

    // pointer and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + LVL_W'(push_n) - LVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // storage, several consecutive slots written at once
    always_ff @(posedge aclk) begin
        for (int k = 0; k < ucf_pkg::MAX_RESULTS; k++) begin
            if (wr_en && (3'(k) < wr_batch.count)) begin
                mem[wr_ptr_reg + PTR_W'(k)] <= wr_batch.entry[k];
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ucf_filter.sv */
// utf8 sequence decoder and filter: input register, one-step decode, string state
`default_nettype none

module ucf_filter (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_data_byte,
    input  wire logic                 s_last_byte,
    input  wire logic [15:0]          max_output_bytes,
    input  wire logic                 fifo_room,
    output logic                      batch_valid,
    output ucf_pkg::ucf_batch_t       batch
);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        step_fire;

    // string state
    logic [7:0]                 held_reg [4];
    logic [7:0]                 held_next [4];
    logic [2:0]                 held_cnt_reg, held_cnt_next;
    logic [2:0]                 seq_len_reg, seq_len_next;
    logic [2:0]                 got_reg, got_next;
    logic [ucf_pkg::CP_W-1:0]   cp_reg, cp_next;
    logic [1:0]                 window_reg, window_next;
    logic [15:0]                emitted_reg, emitted_next;

    // step signals
    logic                       is_cont;
    logic                       lead_ok;
    logic [2:0]                 lead_len;
    logic [ucf_pkg::CP_W-1:0]   lead_bits;
    logic                       start;
    logic                       complete;
    logic [2:0]                 rem;
    logic [2:0]                 rel_n;
    logic [2:0]                 comp_n;
    logic [3:0]                 cand_n;
    logic [15:0]                diff;
    logic [2:0]                 room_n;
    logic [2:0]                 emit_n;
    logic [2:0]                 idx;

    assign step_fire   = in_valid_reg && fifo_room;
    assign s_ready     = !in_valid_reg || step_fire;
    assign batch_valid = step_fire;
    assign is_cont     = (in_byte_reg[7:6] == 2'b10);

    // lead byte patterns
    always_comb begin
        lead_ok   = 1'b1;
        lead_len  = 3'd1;
        lead_bits = {13'd0, in_byte_reg};
        if (!in_byte_reg[7]) begin
            lead_len  = 3'd1;
            lead_bits = {13'd0, in_byte_reg};
        end else if ((in_byte_reg & 8'hE0) == 8'hC0) begin
            lead_len  = 3'd2;
            lead_bits = {16'd0, in_byte_reg[4:0]};
        end else if ((in_byte_reg & 8'hF0) == 8'hE0) begin
            lead_len  = 3'd3;
            lead_bits = {17'd0, in_byte_reg[3:0]};
        end else if ((in_byte_reg & 8'hF8) == 8'hF0) begin
            lead_len  = 3'd4;
            lead_bits = {18'd0, in_byte_reg[2:0]};
        end else begin
            lead_ok = 1'b0;
        end
    end

    // one byte of decode: window release, sequence build, completion, limit
    always_comb begin
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        seq_len_next  = seq_len_reg;
        got_next      = got_reg;
        cp_next       = cp_reg;
        window_next   = window_reg;
        rel_n         = 3'd0;
        comp_n        = 3'd0;
        start         = 1'b0;
        complete      = 1'b0;
        rem           = 3'd0;
        idx           = 3'd0;

        // held bytes go out once the broken lead's length has arrived
        if (window_reg != 2'd0) begin
            window_next = window_reg - 2'd1;
            if (window_next == 2'd0) begin
                rel_n         = (held_cnt_reg > 3'd4) ? 3'd4 : held_cnt_reg;
                held_cnt_next = 3'd0;
            end
        end

        if (seq_len_reg != 3'd0) begin
            if (is_cont) begin
                held_next[2'(held_cnt_next + got_reg)] = in_byte_reg;
                got_next = got_reg + 3'd1;
                cp_next  = {cp_reg[14:0], in_byte_reg[5:0]};
                if (got_next >= seq_len_reg) complete = 1'b1;
            end else begin
                // broken sequence: its missing bytes still open a hold window
                rem = seq_len_reg - 3'd1 - got_reg;
                if (rem > {1'b0, window_next}) window_next = rem[1:0];
                seq_len_next = 3'd0;
                got_next     = 3'd0;
                cp_next      = '0;
                start        = 1'b1;
            end
        end else begin
            start = 1'b1;
        end

        if (start && lead_ok) begin
            held_next[held_cnt_next[1:0]] = in_byte_reg;
            got_next     = 3'd1;
            seq_len_next = lead_len;
            cp_next      = lead_bits;
            if (lead_len == 3'd1) complete = 1'b1;
        end

        if (complete) begin
            if (ucf_pkg::cp_allowed(cp_next)) begin
                if (window_next == 2'd0) begin
                    comp_n = got_next;
                end else begin
                    held_cnt_next = held_cnt_next + got_next;
                end
            end
            seq_len_next = 3'd0;
            got_next     = 3'd0;
            cp_next      = '0;
        end

        // output limit per string
        cand_n = {1'b0, rel_n} + {1'b0, comp_n};
        diff   = max_output_bytes - emitted_reg;
        if (emitted_reg >= max_output_bytes) begin
            room_n = 3'd0;
        end else if (diff >= 16'd4) begin
            room_n = 3'd4;
        end else begin
            room_n = diff[2:0];
        end
        emit_n = (cand_n > {1'b0, room_n}) ? room_n : cand_n[2:0];

        // assemble the results in order: released bytes, then the completed sequence
        batch.count = emit_n;
        for (int k = 0; k < ucf_pkg::MAX_RESULTS; k++) begin
            batch.entry[k] = '0;
            if (3'(k) < emit_n) begin
                if (3'(k) < rel_n) begin
                    batch.entry[k].out_byte = held_reg[2'(k)];
                end else begin
                    idx = {1'b0, held_cnt_next[1:0]} + 3'(k) - rel_n;
                    batch.entry[k].out_byte = held_next[idx[1:0]];
                end
                batch.entry[k].byte_present  = 1'b1;
                batch.entry[k].end_of_string = in_last_reg && (3'(k) == emit_n - 3'd1);
            end
        end

        emitted_next = emitted_reg + {13'd0, emit_n};

        // end of string: bare marker if nothing went out, then clear string state
        if (in_last_reg) begin
            if (emit_n == 3'd0) begin
                batch.count                  = 3'd1;
                batch.entry[0].out_byte      = 8'd0;
                batch.entry[0].byte_present  = 1'b0;
                batch.entry[0].end_of_string = 1'b1;
            end
            held_cnt_next = 3'd0;
            seq_len_next  = 3'd0;
            got_next      = 3'd0;
            cp_next       = '0;
            window_next   = 2'd0;
            emitted_next  = 16'd0;
        end
    end

    // input register handshake
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // string state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt_reg <= 3'd0;
            seq_len_reg  <= 3'd0;
            got_reg      <= 3'd0;
            cp_reg       <= '0;
            window_reg   <= 2'd0;
            emitted_reg  <= 16'd0;
        end else if (step_fire) begin
            held_cnt_reg <= held_cnt_next;
            seq_len_reg  <= seq_len_next;
            got_reg      <= got_next;
            cp_reg       <= cp_next;
            window_reg   <= window_next;
            emitted_reg  <= emitted_next;
        end
    end

    // held bytes, valid only where written earlier in the string
    always_ff @(posedge aclk) begin
        if (step_fire) begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/utf8_codepoint_range_filter.sv */
// top level of the utf8 code point range filter with its configuration port
`default_nettype none
`include "utf8_codepoint_range_filter_assert.svh"

// Takes a string one byte per transaction (with a last-byte flag), decodes UTF-8
// sequences and passes on only whole sequences whose code point is tab, LF, CR,
// printable ASCII, Cyrillic 0x400-0x52F, symbols 0x2600-0x27BF or emoji
// 0x1F300-0x1F64F / 0x1F680-0x1F6FF, each byte as one output transaction, cut
// off after max_output_bytes bytes per string (register 0, reset 4096). The last
// byte of a string always yields a result with end_of_string set, a bare marker
// with byte_present low if no byte went out in that step. One byte is accepted
// per cycle while the queue has room; its results pass through the input register
// and a FIFO_DEPTH-entry result queue, and leave at one per cycle while m_ready is
// high. One byte can release up to four results, so input is held off while the
// queue has fewer than four free entries; over a string there is never more than
// one result per input byte.
module utf8_codepoint_range_filter #(
    parameter int FIFO_DEPTH = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input byte stream
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_data_byte,
    input  wire logic         s_last_byte,
    // result stream
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_byte_present,
    output logic              m_end_of_string,
    // configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    logic [15:0]           max_bytes_reg, max_bytes_next;
    logic                  cfg_wr;
    logic                  fifo_room;
    logic [LVL_W-1:0]      fifo_level;
    logic                  batch_valid;
    ucf_pkg::ucf_batch_t   batch;
    ucf_pkg::ucf_result_t  rd_data;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        max_bytes_next = max_bytes_reg;
        if (cfg_wr && (paddr[2] == ucf_pkg::REG_MAX_OUTPUT_BYTES)) begin
            max_bytes_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= ucf_pkg::MAX_OUTPUT_BYTES_RESET;
        end else begin
            max_bytes_reg <= max_bytes_next;
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == ucf_pkg::REG_MAX_OUTPUT_BYTES) begin
            prdata = {16'd0, max_bytes_reg};
        end
    end

    // decode and filter
    ucf_filter u_filter (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .max_output_bytes (max_bytes_reg),
        .fifo_room        (fifo_room),
        .batch_valid      (batch_valid),
        .batch            (batch)
    );

    // result queue
    ucf_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (batch_valid),
        .wr_batch (batch),
        .rd_data  (rd_data),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .room     (fifo_room),
        .level    (fifo_level)
    );

    assign m_out_byte      = rd_data.out_byte;
    assign m_byte_present  = rd_data.byte_present;
    assign m_end_of_string = rd_data.end_of_string;

    // checks
    `UCF_ASSERT_IMPLIES(a_fifo_bound, aclk, aresetn, 1'b1,
        fifo_level <= LVL_W'(FIFO_DEPTH), "result queue over capacity")
    `UCF_ASSERT_IMPLIES(a_bare_marker_end, aclk, aresetn, m_valid && !m_byte_present,
        m_end_of_string && (m_out_byte == 8'd0), "bare result is not a clean end marker")
    `UCF_ASSERT_IMPLIES(a_batch_fits, aclk, aresetn, batch_valid, fifo_room,
        "batch written without queue room")
    `UCF_ASSERT_NEXT(a_cfg_write, aclk, aresetn,
        cfg_wr && (paddr[2] == ucf_pkg::REG_MAX_OUTPUT_BYTES),
        max_bytes_reg == $past(pwdata[15:0]), "limit register not updated by write")

endmodule

`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for the utf8 code point range filter
`timescale 1ns / 100ps

module tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 330;
    localparam int MAX_REPORTS  = 10;

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    logic [7:0]   s_data_byte;
    logic         s_last_byte;
    logic         m_valid;
    logic         m_ready;
    logic [7:0]   m_out_byte;
    logic         m_byte_present;
    logic         m_end_of_string;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // filter state as the testbench tracks it
    logic [7:0]   hold_buf [4];
    logic [2:0]   hold_cnt;
    logic [2:0]   seq_len;
    logic [2:0]   seq_got;
    logic [20:0]  cp_acc;
    logic [1:0]   skip_left;
    logic [15:0]  out_cnt;
    logic [15:0]  out_limit;

    ucf_pkg::ucf_result_t  step_q [$];
    ucf_pkg::ucf_result_t  filtered_q [$];
    logic [7:0]   text_q [$];

    int           mismatch_count;
    int           bytes_sent;
    bit           gaps_on;
    bit           hold_rx;

    utf8_codepoint_range_filter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_present  (m_byte_present),
        .m_end_of_string (m_end_of_string),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit cp_passes(input logic [20:0] cp);
        bit ok;
        ok = (cp == 21'h09) || (cp == 21'h0A) || (cp == 21'h0D);
        ok = ok || (cp >= 21'h20 && cp <= 21'h7E);
        ok = ok || (cp >= 21'h0400 && cp <= 21'h052F);
        ok = ok || (cp >= 21'h2600 && cp <= 21'h27BF);
        ok = ok || (cp >= 21'h1F300 && cp <= 21'h1F64F);
        ok = ok || (cp >= 21'h1F680 && cp <= 21'h1F6FF);
        return ok;
    endfunction

    // one byte out, unless the string limit or the per-byte cap is reached
    task automatic pass_byte(input logic [7:0] b);
        ucf_pkg::ucf_result_t r;
        if (out_cnt >= out_limit || step_q.size() >= ucf_pkg::MAX_RESULTS) return;
        r.out_byte      = b;
        r.byte_present  = 1'b1;
        r.end_of_string = 1'b0;
        step_q.push_back(r);
        out_cnt++;
    endtask

    task automatic close_sequence();
        if (cp_passes(cp_acc)) begin
            if (skip_left == 2'd0) begin
                for (int i = 0; i < seq_got; i++)
                    pass_byte(hold_buf[2'(hold_cnt + i)]);
            end else begin
                // a dropped lead still owes bytes, keep this sequence back
                hold_cnt = hold_cnt + seq_got;
            end
        end
        seq_len = 3'd0;
        seq_got = 3'd0;
        cp_acc  = '0;
    endtask

    task automatic open_sequence(input logic [7:0] b);
        logic [2:0]  len;
        logic [20:0] bits;
        if (b[7] == 1'b0) begin
            len = 3'd1; bits = {14'd0, b[6:0]};
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2; bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3; bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4; bits = {18'd0, b[2:0]};
        end else begin
            // continuation or 0xf8-0xff as a lead is dropped
            return;
        end
        hold_buf[hold_cnt[1:0]] = b;
        seq_got = 3'd1;
        seq_len = len;
        cp_acc  = bits;
        if (len == 3'd1) close_sequence();
    endtask

    task automatic clear_string();
        hold_cnt  = 3'd0;
        seq_len   = 3'd0;
        seq_got   = 3'd0;
        cp_acc    = '0;
        skip_left = 2'd0;
        out_cnt   = 16'd0;
    endtask

    // results caused by one accepted input byte
    task automatic filter_byte(input logic [7:0] b, input logic last);
        int                   rem;
        ucf_pkg::ucf_result_t r;
        step_q.delete();
        if (skip_left != 2'd0) begin
            skip_left--;
            if (skip_left == 2'd0) begin
                for (int i = 0; i < hold_cnt && i < 4; i++) pass_byte(hold_buf[2'(i)]);
                hold_cnt = 3'd0;
            end
        end
        if (seq_len != 3'd0) begin
            if (b[7:6] == 2'b10) begin
                hold_buf[2'(hold_cnt + seq_got)] = b;
                seq_got++;
                cp_acc = {cp_acc[14:0], b[5:0]};
                if (seq_got >= seq_len) close_sequence();
            end else begin
                // broken sequence: the lead is dropped, the byte starts afresh
                rem = seq_len - 1 - seq_got;
                if (rem > skip_left) skip_left = rem[1:0];
                seq_len = 3'd0;
                seq_got = 3'd0;
                cp_acc  = '0;
                open_sequence(b);
            end
        end else begin
            open_sequence(b);
        end
        if (last) begin
            if (step_q.size() > 0) begin
                r = step_q[step_q.size() - 1];
                r.end_of_string = 1'b1;
                step_q[step_q.size() - 1] = r;
            end else begin
                r.out_byte      = 8'h00;
                r.byte_present  = 1'b0;
                r.end_of_string = 1'b1;
                step_q.push_back(r);
            end
            clear_string();
        end
        foreach (step_q[i]) filtered_q.push_back(step_q[i]);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("ERROR: %s", msg);
    endtask

    task automatic check_result();
        ucf_pkg::ucf_result_t want;
        if (filtered_q.size() == 0) begin
            log_failure($sformatf("result with nothing pending: byte=%02h present=%0b end=%0b",
                                  m_out_byte, m_byte_present, m_end_of_string));
        end else begin
            want = filtered_q.pop_front();
            if (m_out_byte !== want.out_byte || m_byte_present !== want.byte_present ||
                m_end_of_string !== want.end_of_string)
                log_failure({
                    $sformatf("result: expected byte=%02h present=%0b end=%0b",
                              want.out_byte, want.byte_present, want.end_of_string),
                    $sformatf(", got byte=%02h present=%0b end=%0b",
                              m_out_byte, m_byte_present, m_end_of_string)});
        end
    endtask

    // outputs are stable at the falling edge, so sample the handshake there
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) check_result();
    end

    // result sink with random stalls and one long counted hold-off on request
    initial begin : result_sink
        int run;
        int k;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_rx) begin
                // m_ready is already low here
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end else begin
                m_ready <= 1'b1;
                run = ($urandom_range(0, 99) < 20) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
                k = 0;
                do begin
                    @(posedge aclk);
                    k++;
                end while (k < run && !hold_rx);
                m_ready <= 1'b0;
                if (!hold_rx) begin
                    if ($urandom_range(0, 99) < 90) repeat ($urandom_range(1, 3)) @(posedge aclk);
                    else repeat ($urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    // ends the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(negedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic wait_drained();
        do @(posedge aclk); while (filtered_q.size() != 0);
    endtask

    // one input transaction; returns at the edge where it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        bit taken;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            if (taken) begin
                filter_byte(b, last);
                bytes_sent++;
            end
            @(posedge aclk);
        end
    endtask

    // sends text_q as one string; pause_at names a byte after which to drain
    task automatic send_text(input int pause_at);
        int gap;
        foreach (text_q[i]) begin
            send_byte(text_q[i], i == text_q.size() - 1);
            if (i == pause_at) begin
                s_valid <= 1'b0;
                wait_drained();
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // register write while idle, then read back
    task automatic write_limit(input logic [15:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ucf_pkg::REG_MAX_OUTPUT_BYTES, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        out_limit = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata[15:0] !== value)
            log_failure($sformatf("limit register: wrote %0d, read %0d", value, prdata[15:0]));
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // encodes cp in len bytes and appends the first keep of them
    task automatic append_utf8(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] enc [4];
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++) text_q.push_back(enc[2'(i)]);
    endtask

    // a code point in a range, often right at or just past one of its edges
    function automatic logic [20:0] pick_near(input int lo, input int hi);
        case ($urandom_range(0, 11))
            0: return 21'(lo - 1);
            1: return 21'(lo);
            2: return 21'(hi);
            3: return 21'(hi + 1);
            default: return 21'($urandom_range(lo, hi));
        endcase
    endfunction

    // mostly well-formed text with random content, some noise and cut sequences
    task automatic build_random_text();
        int kind;
        int len;
        text_q.delete();
        repeat ($urandom_range(1, 10)) begin
            kind = $urandom_range(0, 99);
            if (kind < 28) begin
                case ($urandom_range(0, 5))
                    0: append_utf8(21'h09, 1, 1);
                    1: append_utf8(21'h0A, 1, 1);
                    2: append_utf8(21'h0D, 1, 1);
                    default: append_utf8(pick_near(8'h20, 8'h7E), 1, 1);
                endcase
            end else if (kind < 40) begin
                append_utf8(pick_near(16'h0400, 16'h052F), 2, 2);
            end else if (kind < 50) begin
                append_utf8(pick_near(16'h2600, 16'h27BF), 3, 3);
            end else if (kind < 60) begin
                if ($urandom_range(0, 1)) append_utf8(pick_near(21'h1F300, 21'h1F64F), 4, 4);
                else append_utf8(pick_near(21'h1F680, 21'h1F6FF), 4, 4);
            end else if (kind < 74) begin
                // any content, including overlong forms and dropped ranges
                len = $urandom_range(1, 4);
                append_utf8(21'($urandom), len, len);
            end else if (kind < 88) begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                // sequence cut short by whatever follows
                len = $urandom_range(2, 4);
                append_utf8(21'($urandom), len, $urandom_range(1, len - 1));
            end
        end
    endtask

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'($urandom_range(2, 6));
            3: return 16'hFFFF;
            4: return ucf_pkg::MAX_OUTPUT_BYTES_RESET;
            default: return 16'($urandom_range(3, 40));
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    // field extremes, some range edges and each special case of the decoder
    task automatic test_directed();
        // controls, zero and DEL; the DEL ends the string with a bare marker
        text_q = '{8'h09, 8'h0A, 8'h0D, 8'h00, 8'h7E, 8'h7F};
        send_text(-1);
        // Cyrillic edges and a dropped two-byte code point
        text_q = '{8'hD0, 8'h80, 8'hD4, 8'hAF, 8'hC3, 8'hA9};
        send_text(-1);
        // symbol and emoji range edges
        text_q = '{8'hE2, 8'h98, 8'h80, 8'hF0, 8'h9F, 8'h9B, 8'hBF};
        send_text(-1);
        // invalid leads, then an overlong space that still passes
        text_q = '{8'h80, 8'hFF, 8'hC0, 8'hA0};
        send_text(-1);
        // broken sequence: bytes after the dropped lead wait for its length
        text_q = '{8'hE2, 8'h41, 8'h42};
        send_text(-1);
        // lead past the end of the string
        text_q = '{8'hF0, 8'h9F};
        send_text(-1);
    endtask

    // the output limit at zero, inside a sequence and at its maximum
    task automatic test_output_limit();
        logic [15:0] limits [4];
        limits = '{16'd0, 16'd2, 16'd4, 16'hFFFF};
        foreach (limits[i]) begin
            write_limit(limits[i]);
            text_q = '{8'h48, 8'hD0, 8'h96, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h21};
            send_text(-1);
        end
    endtask

    // long receiver hold-off while input keeps coming back to back
    task automatic test_full_backpressure();
        text_q.delete();
        repeat (40) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        gaps_on = 1'b0;
        hold_rx = 1'b1;
        send_text(-1);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // sender drains the output while a dropped lead still owes bytes
    task automatic test_sender_pause();
        text_q = '{8'h41, 8'hF0, 8'h42, 8'h43, 8'h44, 8'hE2, 8'h98, 8'h80};
        send_text(2);
    endtask

    task automatic test_random_strings();
        int strings;
        strings = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            if (strings % 5 == 0) write_limit(pick_limit());
            build_random_text();
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) send_text($urandom_range(0, text_q.size() - 1));
            else send_text(-1);
            strings++;
        end
        gaps_on = 1'b1;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data_byte <= 8'h00;
        s_last_byte <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        mismatch_count = 0;
        bytes_sent     = 0;
        gaps_on        = 1'b1;
        hold_rx        = 1'b0;
        for (int i = 0; i < 4; i++) hold_buf[2'(i)] = 8'h00;
        clear_string();
        out_limit = ucf_pkg::MAX_OUTPUT_BYTES_RESET;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_output_limit();
        test_full_backpressure();
        test_sender_pause();
        test_random_strings();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ucf_pkg.sv
hw/rtl/ucf_result_fifo.sv
hw/rtl/ucf_filter.sv
hw/rtl/utf8_codepoint_range_filter.sv
sim/tb.sv
